// File: design/tmcs_pkg.sv
// ----------------------------------------------------------------------------
// tmcs_pkg
// Shared types and constants of the texture mip chain size block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcs_pkg;

  // mip levels handled by default (one lane each)
  localparam int MAX_MIP_LEVELS = 16;

  // alignment of row pitch (strict mode) and of each mip
  localparam int ROW_ALIGN = 256;
  localparam int MIP_ALIGN = 512;

  // field widths
  localparam int EXT_W   = 16;
  localparam int PITCH_W = 21;            // row pitch stays below 2^21 after alignment
  localparam int RD_W    = 2 * EXT_W;     // depth * rows
  localparam int BYTES_W = RD_W + PITCH_W;
  localparam int ALN_W   = BYTES_W + 1;   // after mip alignment
  localparam int TOT_W   = 32;

  typedef struct packed {
    logic [15:0] tex_width;
    logic [15:0] tex_height;
    logic [15:0] tex_depth;
    logic [15:0] array_layers;
    logic [4:0]  mip_count;
    logic [4:0]  mip_cap;
    logic [4:0]  pixel_bytes;
    logic        is_block_format;
    logic [4:0]  block_bytes;
  } in_item_t;

  typedef struct packed {
    logic [31:0] total_bytes;
    logic        size_overflow;
  } out_item_t;

  // stage advance strobes and mode for one mip lane
  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
    logic strict;
  } lane_ctl_t;

endpackage

`default_nettype wire

// File: design/tmcs_lane.sv
// ----------------------------------------------------------------------------
// tmcs_lane
// Size of one mip level in three stages: extents and pitch, depth * rows,
// then times pitch. Gives zero when the level is not counted.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcs_lane #(
  parameter int LEVEL = 0
) (
  input  wire                              clk,
  input  wire tmcs_pkg::lane_ctl_t         ctl,
  input  wire [tmcs_pkg::EXT_W-1:0]        width_i,
  input  wire [tmcs_pkg::EXT_W-1:0]        height_i,
  input  wire [tmcs_pkg::EXT_W-1:0]        depth_i,
  input  wire [4:0]                        pix_i,
  input  wire [4:0]                        blk_i,
  input  wire                              block_i,
  input  wire                              act_i,
  output logic [tmcs_pkg::BYTES_W-1:0]     bytes_o
);

  localparam int EW = tmcs_pkg::EXT_W;
  localparam int PW = tmcs_pkg::PITCH_W;
  localparam int RW = tmcs_pkg::RD_W;
  localparam int BW = tmcs_pkg::BYTES_W;

  logic [EW-1:0] cols, rows, deps, sh_w, sh_h, sh_d;
  logic [EW:0]   cols_p3, rows_p3;
  logic [EW-1:0] rows_s;
  logic [PW-1:0] pitch_lin, pitch_blk, pitch_sel;
  logic [PW:0]   pitch_aln;

  logic [PW-1:0] pitch_r1, pitch_r2;
  logic [EW-1:0] rows_r1, deps_r1;
  logic          act_r1, act_r2;
  logic [RW-1:0] rd_r2;
  logic [BW-1:0] bytes_r3;

  // shrink extents, floor of 1
  always_comb begin
    sh_w = width_i >> LEVEL;
    sh_h = height_i >> LEVEL;
    sh_d = depth_i >> LEVEL;
    cols = (sh_w == '0) ? EW'(1) : sh_w;
    rows = (sh_h == '0) ? EW'(1) : sh_h;
    deps = (sh_d == '0) ? EW'(1) : sh_d;
  end

  // linear or block pitch, optional row alignment
  always_comb begin
    cols_p3   = {1'b0, cols} + (EW+1)'(3);
    rows_p3   = {1'b0, rows} + (EW+1)'(3);
    pitch_lin = PW'({5'b0, cols} * {16'b0, pix_i});
    if (pitch_lin == '0) begin
      pitch_lin = PW'(1);
    end
    pitch_blk = PW'({6'b0, cols_p3[EW:2]} * {16'b0, blk_i});
    if (block_i) begin
      pitch_sel = pitch_blk;
      rows_s    = {1'b0, rows_p3[EW:2]};
    end else begin
      pitch_sel = pitch_lin;
      rows_s    = rows;
    end
    pitch_aln = ({1'b0, pitch_sel} + (PW+1)'(tmcs_pkg::ROW_ALIGN - 1))
                & ~(PW+1)'(tmcs_pkg::ROW_ALIGN - 1);
  end

  // stage 1: pitch and extents
  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      pitch_r1 <= ctl.strict ? pitch_aln[PW-1:0] : pitch_sel;
      rows_r1  <= rows_s;
      deps_r1  <= deps;
      act_r1   <= act_i;
    end
  end

  // stage 2: depth times rows
  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      rd_r2    <= {{EW{1'b0}}, deps_r1} * {{EW{1'b0}}, rows_r1};
      pitch_r2 <= pitch_r1;
      act_r2   <= act_r1;
    end
  end

  // stage 3: times pitch, drop uncounted levels
  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      bytes_r3 <= act_r2 ? BW'({{PW{1'b0}}, rd_r2} * {{RW{1'b0}}, pitch_r2}) : '0;
    end
  end

  assign bytes_o = bytes_r3;

endmodule

`default_nettype wire

// File: design/tmcs_reduce.sv
// ----------------------------------------------------------------------------
// tmcs_reduce
// Aligns each mip size to 512 bytes, sums the lanes in a registered tree,
// then multiplies by the layer count and flags overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcs_reduce #(
  parameter int PAD = 16,
  parameter int TL  = 4
) (
  input  wire                                   clk,
  input  wire  [TL+1:0]                         adv,
  input  wire  [PAD-1:0][tmcs_pkg::BYTES_W-1:0] bytes_i,
  input  wire  [15:0]                           layers_i,
  output tmcs_pkg::out_item_t                   res_o
);

  localparam int AW = tmcs_pkg::ALN_W;
  localparam int SW = AW + TL;
  localparam int HP = PAD / 2;

  logic [SW-1:0] node_r [TL][HP];
  logic [15:0]   lay_r  [TL];
  logic [47:0]   prod_r;
  logic          hi_r, lay_nz_r;
  logic [31:0]   tot_r;
  logic          ovf_r;
  logic [AW-1:0] aln [PAD];

  // align each mip to 512 bytes
  always_comb begin
    for (int i = 0; i < PAD; i++) begin
      aln[i] = ({1'b0, bytes_i[i]} + AW'(tmcs_pkg::MIP_ALIGN - 1))
               & ~AW'(tmcs_pkg::MIP_ALIGN - 1);
    end
  end

  // summing tree, one level per stage
  for (genvar k = 0; k < TL; k++) begin : g_lvl
    for (genvar i = 0; i < HP; i++) begin : g_node
      if (i >= (PAD >> (k + 1))) begin : g_zero
        always_ff @(posedge clk) begin
          if (adv[k]) begin
            node_r[k][i] <= '0;
          end
        end
      end else if (k == 0) begin : g_leaf
        always_ff @(posedge clk) begin
          if (adv[k]) begin
            node_r[k][i] <= SW'(aln[2*i]) + SW'(aln[2*i+1]);
          end
        end
      end else begin : g_sum
        always_ff @(posedge clk) begin
          if (adv[k]) begin
            node_r[k][i] <= node_r[k-1][2*i] + node_r[k-1][2*i+1];
          end
        end
      end
    end
    if (k == 0) begin : g_lay0
      always_ff @(posedge clk) begin
        if (adv[k]) begin
          lay_r[k] <= layers_i;
        end
      end
    end else begin : g_layn
      always_ff @(posedge clk) begin
        if (adv[k]) begin
          lay_r[k] <= lay_r[k-1];
        end
      end
    end
  end

  // multiply by layers; high slice bits mean overflow unless layers is zero
  always_ff @(posedge clk) begin
    if (adv[TL]) begin
      prod_r   <= {16'b0, node_r[TL-1][0][31:0]} * {32'b0, lay_r[TL-1]};
      hi_r     <= |node_r[TL-1][0][SW-1:32];
      lay_nz_r <= |lay_r[TL-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv[TL+1]) begin
      tot_r <= prod_r[31:0];
      ovf_r <= (hi_r & lay_nz_r) | (|prod_r[47:32]);
    end
  end

  assign res_o.total_bytes   = tot_r;
  assign res_o.size_overflow = ovf_r;

endmodule

`default_nettype wire

// File: design/texture_mip_chain_size_top.sv
// ----------------------------------------------------------------------------
// texture_mip_chain_size_top
// Upload buffer size of a texture mip chain, one lane per mip level.
//
//   channel | ports                          | direction
//   in      | in_valid, in_stall, in_data    | texture description in
//   out     | out_valid, out_stall, out_data | size and overflow flag out
//   cfg     | cfg_wr_en, cfg_wr_data         | strict row alignment bit
//
// Stages in order: three lane stages, the summing tree, the layer multiply
// and the output register.
// An item can enter every cycle unless stalled; each stage holds its item
// until the next stage is free, so bubbles close up behind a stalled output.
// Synchronous active-low reset clears the valid bits and the mode bit.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_mip_chain_size_top #(
  parameter int MAX_MIP_LEVELS = tmcs_pkg::MAX_MIP_LEVELS
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire tmcs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output tmcs_pkg::out_item_t      out_data,
  input  wire                      cfg_wr_en,
  input  wire                      cfg_wr_data
);

  localparam int TL  = (MAX_MIP_LEVELS > 1) ? $clog2(MAX_MIP_LEVELS) : 1;
  localparam int PAD = 1 << TL;
  localparam int NS  = TL + 5;

  logic                   strict_r;
  logic [NS:1]            v_r;
  logic [NS+1:1]          en;
  logic [4:0]             mips;
  logic [15:0]            lay_r [3];
  tmcs_pkg::lane_ctl_t    ctl;
  logic [PAD-1:0][tmcs_pkg::BYTES_W-1:0] bytes;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b0;
    end else if (cfg_wr_en) begin
      strict_r <= cfg_wr_data;
    end
  end

  // advance a stage when it is empty or the next one advances
  always_comb begin
    en[NS+1] = !out_stall;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 1) ? in_valid : v_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v_r[NS];

  // mips counted: cap applies when nonzero and smaller
  always_comb begin
    mips = in_data.mip_count;
    if (in_data.mip_cap != '0 && in_data.mip_cap < in_data.mip_count) begin
      mips = in_data.mip_cap;
    end
  end

  assign ctl.adv1   = en[1];
  assign ctl.adv2   = en[2];
  assign ctl.adv3   = en[3];
  assign ctl.strict = strict_r;

  // mip lanes, unused pad lanes give zero
  for (genvar m = 0; m < PAD; m++) begin : g_lane
    if (m < MAX_MIP_LEVELS) begin : g_real
      tmcs_lane #(.LEVEL(m)) u_lane (
        .clk      (clk),
        .ctl      (ctl),
        .width_i  (in_data.tex_width),
        .height_i (in_data.tex_height),
        .depth_i  (in_data.tex_depth),
        .pix_i    (in_data.pixel_bytes),
        .blk_i    (in_data.block_bytes),
        .block_i  (in_data.is_block_format),
        .act_i    (mips > 5'(m)),
        .bytes_o  (bytes[m])
      );
    end else begin : g_pad
      assign bytes[m] = '0;
    end
  end

  // carry layer count alongside the lane stages
  always_ff @(posedge clk) begin
    if (en[1]) begin
      lay_r[0] <= in_data.array_layers;
    end
    if (en[2]) begin
      lay_r[1] <= lay_r[0];
    end
    if (en[3]) begin
      lay_r[2] <= lay_r[1];
    end
  end

  tmcs_reduce #(.PAD(PAD), .TL(TL)) u_reduce (
    .clk      (clk),
    .adv      (en[NS:4]),
    .bytes_i  (bytes),
    .layers_i (lay_r[2]),
    .res_o    (out_data)
  );

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[1])
    else $error("accepted item did not enter stage 1");
  a_empty_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[NS] |-> !in_stall)
    else $error("input stalled with empty output stage");
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !v_r[NS-1] |=> !out_valid)
    else $error("result repeated");
  a_hold_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && !en[1] |=> v_r[1])
    else $error("stalled stage 1 item lost");
`endif

endmodule

`default_nettype wire

// File: bench/texture_mip_chain_size_top_tb.sv
// ----------------------------------------------------------------------------
// texture_mip_chain_size_top_tb
// Drives texture descriptions into the mip chain size block, predicts the
// buffer size and overflow flag for each, and checks results in order.
// Covers both alignment modes, field extremes, random items and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module texture_mip_chain_size_top_tb;

  localparam int LATENCY = 9;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tmcs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tmcs_pkg::out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  tmcs_pkg::in_item_t pending_items[$];
  tmcs_pkg::out_item_t expected_sizes[$];
  logic strict_mode = 1'b0;
  int errors = 0;
  bit quiet_idle = 1'b0;
  int hold_off = 0;
  bit feeding = 1'b0;
  bit in_taken = 1'b0;

  texture_mip_chain_size_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Compute the expected buffer size for one texture description
  function automatic tmcs_pkg::out_item_t chain_size(tmcs_pkg::in_item_t t, logic strict);
    tmcs_pkg::out_item_t r;
    int unsigned mips;
    longint unsigned slice, cols, rows, deps, pitch, bp, bytes, exact;
    slice = 0;
    mips = t.mip_count;
    if (t.mip_cap > 0 && t.mip_cap < mips) mips = t.mip_cap;
    if (mips > tmcs_pkg::MAX_MIP_LEVELS) mips = tmcs_pkg::MAX_MIP_LEVELS;
    for (int m = 0; m < mips; m++) begin
      cols = t.tex_width >> m;  if (cols < 1) cols = 1;
      rows = t.tex_height >> m; if (rows < 1) rows = 1;
      deps = t.tex_depth >> m;  if (deps < 1) deps = 1;
      pitch = cols * t.pixel_bytes;
      if (pitch < 1) pitch = 1;
      if (t.is_block_format) begin
        bp = ((cols + 3) / 4) * t.block_bytes;
        rows = (rows + 3) / 4;
        if (rows < 1) rows = 1;
        pitch = (bp < t.block_bytes) ? t.block_bytes : bp;
      end
      if (strict) pitch = (pitch + 255) & ~64'd255;
      bytes = (deps * rows * pitch + 511) & ~64'd511;
      slice += bytes;
    end
    if (t.array_layers == 0) begin
      r.total_bytes = '0;
      r.size_overflow = 1'b0;
    end else if (slice > 64'hFFFF_FFFF) begin
      r.total_bytes = 32'((slice & 64'hFFFF_FFFF) * t.array_layers);
      r.size_overflow = 1'b1;
    end else begin
      exact = slice * t.array_layers;
      r.total_bytes = exact[31:0];
      r.size_overflow = exact > 64'hFFFF_FFFF;
    end
    return r;
  endfunction

  function automatic tmcs_pkg::in_item_t rand_item();
    tmcs_pkg::in_item_t t;
    int sel;
    sel = $urandom_range(0, 9);
    t.tex_width  = (sel < 6) ? 16'($urandom_range(1, 300)) : 16'($urandom);
    t.tex_height = (sel < 6) ? 16'($urandom_range(1, 300)) : 16'($urandom);
    t.tex_depth  = (sel < 3) ? 16'($urandom_range(1, 8)) : 16'($urandom);
    t.array_layers = (sel < 7) ? 16'($urandom_range(0, 6)) : 16'($urandom);
    t.mip_count = 5'($urandom);
    t.mip_cap = 5'($urandom);
    t.pixel_bytes = 5'($urandom);
    t.is_block_format = 1'($urandom);
    t.block_bytes = 5'($urandom);
    return t;
  endfunction

  // Driver: present the next item at the falling edge, hold until accepted
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (feeding && pending_items.size() > 0 &&
          (quiet_idle || $urandom_range(0, 99) >= 7)) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Record expectations at acceptance
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_sizes.push_back(chain_size(in_data, strict_mode));
  end

  // Receiver stall: long hold-off on request, random otherwise
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= !quiet_idle && ($urandom_range(0, 99) < 7);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    tmcs_pkg::out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sizes.size() == 0) begin
        $error("unexpected result total_bytes=%0h", out_data.total_bytes);
        errors++;
      end else begin
        exp_r = expected_sizes.pop_front();
        if (out_data.total_bytes !== exp_r.total_bytes) begin
          $error("total_bytes expected %0h actual %0h",
                 exp_r.total_bytes, out_data.total_bytes);
          errors++;
        end
        if (out_data.size_overflow !== exp_r.size_overflow) begin
          $error("size_overflow expected %0b actual %0b",
                 exp_r.size_overflow, out_data.size_overflow);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    feeding = 1'b1;
    while (pending_items.size() != 0 || in_valid || expected_sizes.size() != 0)
      @(posedge clk);
    feeding = 1'b0;
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_strict(logic v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    strict_mode = v;
  endtask

  function automatic tmcs_pkg::in_item_t make_item(int w, int h, int d, int l, int mc,
                                                   int cap, int pb, int blk, int bb);
    tmcs_pkg::in_item_t t;
    t.tex_width = 16'(w); t.tex_height = 16'(h); t.tex_depth = 16'(d);
    t.array_layers = 16'(l); t.mip_count = 5'(mc); t.mip_cap = 5'(cap);
    t.pixel_bytes = 5'(pb); t.is_block_format = 1'(blk); t.block_bytes = 5'(bb);
    return t;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes and special cases, in both modes
    for (int s = 0; s < 2; s++) begin
      write_strict(s[0]);
      pending_items.push_back(make_item(1, 1, 1, 1, 1, 0, 4, 0, 0));
      pending_items.push_back(make_item(65535, 65535, 65535, 65535, 31, 31, 31, 1, 31));
      pending_items.push_back(make_item(0, 0, 0, 1, 3, 0, 4, 0, 0));
      pending_items.push_back(make_item(16, 16, 1, 1, 0, 0, 4, 0, 0));
      pending_items.push_back(make_item(16, 16, 1, 1, 8, 0, 4, 0, 0));
      pending_items.push_back(make_item(1024, 512, 1, 2, 16, 4, 4, 0, 0));
      pending_items.push_back(make_item(1024, 512, 1, 2, 20, 0, 4, 0, 0));
      pending_items.push_back(make_item(100, 30, 2, 3, 5, 0, 0, 0, 0));
      pending_items.push_back(make_item(256, 256, 1, 6, 9, 0, 0, 1, 16));
      pending_items.push_back(make_item(256, 256, 1, 6, 9, 0, 0, 1, 0));
      pending_items.push_back(make_item(7, 3, 1, 0, 4, 0, 16, 0, 0));
      pending_items.push_back(make_item(65535, 65535, 1, 65535, 16, 16, 16, 0, 0));
      drain();
    end

    // Long receiver hold-off while items keep coming
    write_strict(1'b0);
    quiet_idle = 1'b1;
    for (int i = 0; i < 60; i++) pending_items.push_back(rand_item());
    hold_off = 200;
    drain();
    quiet_idle = 1'b0;

    // Random phases, switching mode between them
    for (int ph = 0; ph < 8; ph++) begin
      write_strict(ph[0]);
      quiet_idle = (ph == 3);
      for (int i = 0; i < 100; i++) pending_items.push_back(rand_item());
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
